[hdl/adrp_pkg.sv]
// ----------------------------------------------------------------------------
// adrp_pkg
// Shared constants and types for the ADRP/ADD pair address resolver.
// ----------------------------------------------------------------------------
package adrp_pkg;

    localparam int DEF_ADDR_WIDTH = 64;
    localparam int REG_W          = 5;
    localparam int WORD_W         = 32;
    localparam int ADRP_IMM_W     = 21;
    localparam int ADD_IMM_W      = 24;
    localparam int PAGE_SHIFT     = 12;

    localparam logic [WORD_W-1:0] ADRP_MASK = 32'h9F00_0000;
    localparam logic [WORD_W-1:0] ADRP_CODE = 32'h9000_0000;
    localparam logic [WORD_W-1:0] ADDI_MASK = 32'hFF00_0000;
    localparam logic [WORD_W-1:0] ADDI_CODE = 32'h9100_0000;

    localparam logic [REG_W-1:0] TARGET_RESET = 5'd2;

    typedef struct packed {
        logic                  dst_match;
        logic                  is_adrp;
        logic                  is_addi_pair;
        logic [ADRP_IMM_W-1:0] adrp_imm;
        logic [ADD_IMM_W-1:0]  add_imm;
    } t_dec;

endpackage

[hdl/adrp_in_if.sv]
// ----------------------------------------------------------------------------
// adrp_in_if
// Request channel: instruction word, its address and the end-of-window flag.
// ----------------------------------------------------------------------------
interface adrp_in_if #(
    parameter int ADDR_WIDTH = adrp_pkg::DEF_ADDR_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic [adrp_pkg::WORD_W-1:0]    insn_word;
    logic [ADDR_WIDTH-1:0]          insn_addr;
    logic                           last_word;

    modport source (output valid, output insn_word, output insn_addr, output last_word,
                    input ready);
    modport sink   (input valid, input insn_word, input insn_addr, input last_word,
                    output ready);
endinterface

[hdl/adrp_out_if.sv]
// ----------------------------------------------------------------------------
// adrp_out_if
// Result channel: hit flag, resolved address and end-of-scan echo.
// ----------------------------------------------------------------------------
interface adrp_out_if #(
    parameter int ADDR_WIDTH = adrp_pkg::DEF_ADDR_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [ADDR_WIDTH-1:0] resolved_addr;
    logic                  scan_end;

    modport source (output valid, output hit, output resolved_addr, output scan_end,
                    input ready);
    modport sink   (input valid, input hit, input resolved_addr, input scan_end,
                    output ready);
endinterface

[hdl/adrp_decode.sv]
// ----------------------------------------------------------------------------
// adrp_decode
// Field decode of one instruction word against the target register.
// ----------------------------------------------------------------------------
module adrp_decode (
    input  logic [adrp_pkg::WORD_W-1:0] i_word,
    input  logic [adrp_pkg::REG_W-1:0]  i_target,
    output adrp_pkg::t_dec              o_dec
);

    logic [11:0] w_imm12;

    assign w_imm12 = i_word[21:10];

    always_comb begin
        o_dec.dst_match    = (i_word[4:0] == i_target);
        o_dec.is_adrp      = ((i_word & adrp_pkg::ADRP_MASK) == adrp_pkg::ADRP_CODE);
        o_dec.is_addi_pair = ((i_word & adrp_pkg::ADDI_MASK) == adrp_pkg::ADDI_CODE)
                             && (i_word[9:5] == i_target);
        o_dec.adrp_imm     = {i_word[23:5], i_word[30:29]};
        if (i_word[22]) begin
            o_dec.add_imm = {w_imm12, 12'd0};
        end else begin
            o_dec.add_imm = {12'd0, w_imm12};
        end
    end

endmodule

[hdl/adrp_core.sv]
// ----------------------------------------------------------------------------
// adrp_core
// Scan state (armed page, found flag) and pair resolution for one word.
// ----------------------------------------------------------------------------
module adrp_core #(
    parameter int ADDR_WIDTH = adrp_pkg::DEF_ADDR_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  adrp_pkg::t_dec        i_dec,
    input  logic [ADDR_WIDTH-1:0] i_addr,
    input  logic                  i_last,
    output logic                  o_hit,
    output logic [ADDR_WIDTH-1:0] o_res
);

    logic                  r_armed;
    logic                  r_found;
    logic [ADDR_WIDTH-1:0] r_page;
    logic                  n_armed;
    logic                  n_found;
    logic                  w_active;
    logic                  w_load;
    logic [ADDR_WIDTH-1:0] w_off;
    logic [ADDR_WIDTH-1:0] w_new_page;
    logic [ADDR_WIDTH-1:0] w_sum;

    assign w_active = !r_found && i_dec.dst_match;
    assign o_hit    = w_active && r_armed && i_dec.is_addi_pair;
    assign w_load   = w_active && !o_hit && i_dec.is_adrp;

    assign w_off = {{(ADDR_WIDTH-adrp_pkg::ADRP_IMM_W){i_dec.adrp_imm[adrp_pkg::ADRP_IMM_W-1]}},
                    i_dec.adrp_imm} << adrp_pkg::PAGE_SHIFT;
    assign w_new_page = {i_addr[ADDR_WIDTH-1:adrp_pkg::PAGE_SHIFT],
                         {adrp_pkg::PAGE_SHIFT{1'b0}}} + w_off;
    assign w_sum = r_page + {{(ADDR_WIDTH-adrp_pkg::ADD_IMM_W){1'b0}}, i_dec.add_imm};
    assign o_res = o_hit ? w_sum : '0;

    always_comb begin
        n_armed = w_active ? w_load : r_armed;
        n_found = r_found || o_hit;
        if (i_last) begin
            n_armed = 1'b0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_found <= 1'b0;
            r_page  <= '0;
        end else if (i_step) begin
            r_armed <= n_armed;
            r_found <= n_found;
            if (w_load) begin
                r_page <= w_new_page;
            end
        end
    end

`ifndef ASSERT_OFF
    a_found_not_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_found && r_armed))
        else $error("page armed after the scan already hit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> !r_found && !r_armed)
        else $error("scan state survived the last word");

    a_hit_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_hit && !i_last |=> r_found)
        else $error("hit did not mark the scan found");
`endif

endmodule

[hdl/adrp_add_address_resolver_top.sv]
// ----------------------------------------------------------------------------
// adrp_add_address_resolver_top
// Streams instruction words and resolves the first ADRP/ADD pair on the
// configured register into a full address, one result per word.
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    insn_word, insn_addr, last_word
//   o_rsp     out  valid/ready    hit, resolved_addr, scan_end
//   i_cfg_*   in   write enable   target_reg (5 bits)
//
// One word per cycle while results are taken; a word passes the input
// register, then the result register, with decode and one page add between.
// Synchronous active-low reset clears both stages and the scan state;
// target_reg resets to 2.
// A stalled result holds in the result register; a new request is still
// taken while the input stage is empty or moving.
// ----------------------------------------------------------------------------
module adrp_add_address_resolver_top #(
    parameter int ADDR_WIDTH = adrp_pkg::DEF_ADDR_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [adrp_pkg::REG_W-1:0] i_cfg_wdata,
    adrp_in_if.sink                    i_req,
    adrp_out_if.source                 o_rsp
);

    logic [adrp_pkg::REG_W-1:0]  r_target;
    logic                        r_s1_valid;
    logic [adrp_pkg::WORD_W-1:0] r_s1_word;
    logic [ADDR_WIDTH-1:0]       r_s1_addr;
    logic                        r_s1_last;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [ADDR_WIDTH-1:0]       r_out_addr;
    logic                        r_out_end;

    logic                  w_advance;
    logic                  w_step;
    logic                  w_accept;
    adrp_pkg::t_dec        w_dec;
    logic                  w_hit;
    logic [ADDR_WIDTH-1:0] w_res;

    assign w_advance   = !r_out_valid || o_rsp.ready;
    assign w_step      = r_s1_valid && w_advance;
    assign i_req.ready = !r_s1_valid || w_advance;
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.resolved_addr = r_out_addr;
    assign o_rsp.scan_end      = r_out_end;

    adrp_decode u_decode (
        .i_word   (r_s1_word),
        .i_target (r_target),
        .o_dec    (w_dec)
    );

    adrp_core #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_dec   (w_dec),
        .i_addr  (r_s1_addr),
        .i_last  (r_s1_last),
        .o_hit   (w_hit),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= adrp_pkg::TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_word <= i_req.insn_word;
            r_s1_addr <= i_req.insn_addr;
            r_s1_last <= i_req.last_word;
        end
        if (w_step) begin
            r_out_hit  <= w_hit;
            r_out_addr <= w_res;
            r_out_end  <= r_s1_last;
        end
    end

`ifndef ASSERT_OFF
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_addr == '0)
        else $error("nonzero address on a miss");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("request advanced but no result held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_out_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

[dv/adrp_add_address_resolver_chk.sv]
// ----------------------------------------------------------------------------
// adrp_add_address_resolver_chk
// Watches the request, result and register-write ports of the resolver,
// predicts the result of every accepted request from its own copy of the
// scan state and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module adrp_add_address_resolver_chk #(
    parameter int ADDR_WIDTH = adrp_pkg::DEF_ADDR_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [adrp_pkg::REG_W-1:0] i_cfg_wdata,
    adrp_in_if                         i_req,
    adrp_out_if                        i_rsp,
    output int                         o_fail_cnt,
    output int                         o_pending
);

    typedef struct packed {
        logic                  hit;
        logic [ADDR_WIDTH-1:0] addr;
        logic                  scan_end;
    } t_resolve;

    t_resolve                   resolved_q[$];
    logic [adrp_pkg::REG_W-1:0] target_reg;
    logic                       page_armed;
    logic [ADDR_WIDTH-1:0]      page_base;
    logic                       scan_found;
    int                         fails;

    always @(posedge i_clk) begin : resolve_pairs
        t_resolve                        want;
        t_resolve                        got;
        t_resolve                        pred;
        logic [adrp_pkg::WORD_W-1:0]     w;
        logic [adrp_pkg::ADRP_IMM_W-1:0] imm21;
        logic [ADDR_WIDTH-1:0]           imm;
        logic                            is_hit;
        logic [ADDR_WIDTH-1:0]           res;

        if (!i_rst_n) begin
            target_reg = adrp_pkg::TARGET_RESET;
            page_armed = 1'b0;
            page_base  = '0;
            scan_found = 1'b0;
            fails      = 0;
            resolved_q.delete();
        end else begin
            if (i_cfg_we) begin
                target_reg = i_cfg_wdata;
            end

            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.hit, i_rsp.resolved_addr, i_rsp.scan_end};
                if (resolved_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result hit=%0b addr=%h scan_end=%0b",
                             $time, got.hit, got.addr, got.scan_end);
                end else begin
                    want = resolved_q.pop_front();
                    if (want.hit !== got.hit) begin
                        fails++;
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, want.hit, got.hit);
                    end
                    if (want.addr !== got.addr) begin
                        fails++;
                        $display("%0t: resolved_addr expected %h actual %h",
                                 $time, want.addr, got.addr);
                    end
                    if (want.scan_end !== got.scan_end) begin
                        fails++;
                        $display("%0t: scan_end expected %0b actual %0b",
                                 $time, want.scan_end, got.scan_end);
                    end
                end
            end

            if (i_req.valid && i_req.ready) begin
                w      = i_req.insn_word;
                is_hit = 1'b0;
                res    = '0;
                if (!scan_found && w[adrp_pkg::REG_W-1:0] == target_reg) begin
                    if (page_armed) begin
                        if ((w & adrp_pkg::ADDI_MASK) == adrp_pkg::ADDI_CODE
                            && w[9:5] == target_reg) begin
                            imm = ADDR_WIDTH'(w[21:10]);
                            if (w[22]) begin
                                imm = imm << adrp_pkg::PAGE_SHIFT;
                            end
                            res        = page_base + imm;
                            is_hit     = 1'b1;
                            scan_found = 1'b1;
                        end
                        page_armed = 1'b0;
                    end
                    if (!is_hit && (w & adrp_pkg::ADRP_MASK) == adrp_pkg::ADRP_CODE) begin
                        imm21     = {w[23:5], w[30:29]};
                        page_base = {i_req.insn_addr[ADDR_WIDTH-1:adrp_pkg::PAGE_SHIFT],
                                     {adrp_pkg::PAGE_SHIFT{1'b0}}}
                                  + ({{(ADDR_WIDTH-adrp_pkg::ADRP_IMM_W)
                                       {imm21[adrp_pkg::ADRP_IMM_W-1]}}, imm21}
                                     << adrp_pkg::PAGE_SHIFT);
                        page_armed = 1'b1;
                    end
                end
                if (i_req.last_word) begin
                    page_armed = 1'b0;
                    scan_found = 1'b0;
                end
                pred = '{is_hit, res, i_req.last_word};
                resolved_q.insert(resolved_q.size(), pred);
            end
        end

        o_pending  <= resolved_q.size();
        o_fail_cnt <= fails;
    end

endmodule

[dv/tb_adrp_add_address_resolver_top.sv]
// ----------------------------------------------------------------------------
// tb_adrp_add_address_resolver_top
// Drives instruction-word requests into the resolver: a directed set of
// corner cases, then random scans built mostly from ADRP/ADD pairs on the
// selected register mixed with noise, across several register settings.
// Both handshake sides idle at random; the result side also holds off long
// enough to back up the block. The checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_adrp_add_address_resolver_top;

    typedef logic [adrp_pkg::REG_W-1:0]      t_reg;
    typedef logic [adrp_pkg::WORD_W-1:0]     t_word;
    typedef logic [adrp_pkg::ADRP_IMM_W-1:0] t_adrp_imm;

    localparam int    AW         = adrp_pkg::DEF_ADDR_WIDTH;
    localparam int    IDLE_LIMIT = 1000;
    localparam t_word SF_BIT     = 32'h8000_0000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_reg cfg_wdata;
    int   fail_cnt;
    int   pending;
    int   sent_cnt;
    int   idle_cycles;
    bit   calm;
    t_reg tgt;

    adrp_in_if  #(.ADDR_WIDTH(AW)) req_if ();
    adrp_out_if #(.ADDR_WIDTH(AW)) rsp_if ();

    adrp_add_address_resolver_top #(.ADDR_WIDTH(AW)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    adrp_add_address_resolver_chk #(.ADDR_WIDTH(AW)) i_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_word adrp_enc(input t_reg rd, input t_adrp_imm imm);
        return adrp_pkg::ADRP_CODE | {1'b0, imm[1:0], 5'b0, imm[20:2], rd};
    endfunction

    function automatic t_word addi_enc(input t_reg rd,
                                       input t_reg rn,
                                       input logic [11:0] imm,
                                       input logic sh, input logic b23);
        return adrp_pkg::ADDI_CODE | {8'b0, b23, sh, imm, rn, rd};
    endfunction

    function automatic t_word word_to(input t_reg rd);
        t_word w;
        w = $urandom;
        return {w[adrp_pkg::WORD_W-1:adrp_pkg::REG_W], rd};
    endfunction

    function automatic t_reg other_reg(input t_reg rd);
        return rd + t_reg'($urandom_range(1, 31));
    endfunction

    task automatic send_word(input t_word w, input logic [AW-1:0] a,
                             input logic eow);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.insn_word <= w;
        req_if.insn_addr <= a;
        req_if.last_word <= eow;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sent_cnt++;
    endtask

    // drain all outstanding results before touching the register
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_target(input t_reg r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        tgt        = r;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : rsp_sink
        int holds;
        holds        = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if ((holds == 0 && sent_cnt >= 60) || (holds == 1 && sent_cnt >= 250)) begin
                holds++;
                rsp_if.ready <= 1'b0;
                repeat (80) @(posedge clk);
            end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            rsp_if.ready <= rst_n;
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_reg          targets[5];
        logic [AW-1:0] pc;
        int            cnt;
        int            kind;
        int            ph;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_if.valid     = 1'b0;
        req_if.insn_word = '0;
        req_if.insn_addr = '0;
        req_if.last_word = 1'b0;
        sent_cnt         = 0;
        calm             = 1'b0;
        tgt              = adrp_pkg::TARGET_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(adrp_enc(tgt, 21'd0), 64'h0000_0000_0000_1234, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'hFFF, 1'b0, 1'b0), 64'h1238, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'h001, 1'b1, 1'b0), 64'h123C, 1'b0);
        send_word(32'hFFFF_FFFF, 64'h1240, 1'b1);
        send_word(adrp_enc(tgt, 21'h0F_FFFF), '1, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'hFFF, 1'b1, 1'b1), 64'h0, 1'b1);
        send_word(adrp_enc(tgt, 21'h10_0000), 64'h0, 1'b0);
        send_word(adrp_enc(tgt + 5'd1, '1), 64'h4, 1'b0);
        send_word(addi_enc(tgt, tgt + 5'd1, 12'h555, 1'b0, 1'b0), 64'h8, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'h800, 1'b0, 1'b0), 64'hC, 1'b0);
        send_word(adrp_enc(tgt, 21'h12345), 64'hFFFF_0000_8000_0FFC, 1'b0);
        send_word(adrp_enc(tgt, 21'h1F_FFFF), 64'h8000_0000_0000_0000, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'hABC, 1'b1, 1'b0), 64'h8000_0000_0000_0004, 1'b1);
        send_word(adrp_enc(tgt, 21'h00001), 64'h5555_5555_5555_5555, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'h123, 1'b0, 1'b0) & ~SF_BIT, 64'h5555_5555_5555_5559,
                  1'b0);
        send_word(addi_enc(tgt, tgt, 12'h123, 1'b0, 1'b0), 64'h5555_5555_5555_555D, 1'b1);
        send_word(adrp_enc(tgt, 21'h0ABCD), 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(adrp_enc(tgt, 21'h0ABCD) & ~SF_BIT, 64'hAAAA_AAAA_AAAA_AAAE, 1'b0);
        send_word(addi_enc(tgt, tgt, 12'h010, 1'b0, 1'b0), 64'hAAAA_AAAA_AAAA_AAB2, 1'b0);
        send_word(32'h0, 64'h0, 1'b1);
        send_word(adrp_enc(tgt, 21'h3), 64'h7000, 1'b1);
        send_word(addi_enc(tgt, tgt, 12'h7FF, 1'b1, 1'b0), 64'h7004, 1'b0);

        targets[0] = t_reg'($urandom);
        targets[1] = '0;
        targets[2] = '1;
        targets[3] = t_reg'($urandom);
        targets[4] = adrp_pkg::TARGET_RESET;

        for (ph = 0; ph < 5; ph++) begin
            set_target(targets[ph]);
            cnt = 0;
            while (cnt < 90) begin
                if (ph == 4 && cnt >= 40) begin
                    calm = 1'b1;
                end
                pc = {$urandom, $urandom};
                if ($urandom_range(0, 3) != 0) begin
                    pc[1:0] = 2'b00;
                end
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    repeat ($urandom_range(0, 2)) begin
                        send_word(word_to(other_reg(tgt)), pc, 1'b0);
                        pc += 4;
                        cnt++;
                    end
                    send_word(adrp_enc(tgt, t_adrp_imm'($urandom)), pc, 1'b0);
                    pc += 4;
                    cnt++;
                    repeat ($urandom_range(0, 3)) begin
                        send_word(word_to(other_reg(tgt)), pc, 1'b0);
                        pc += 4;
                        cnt++;
                    end
                    send_word(addi_enc(tgt, tgt, 12'($urandom), 1'($urandom), 1'($urandom)),
                              pc, $urandom_range(0, 3) == 0);
                    pc += 4;
                    cnt++;
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_word(addi_enc(tgt, tgt, 12'($urandom), 1'($urandom),
                                               1'($urandom)), pc, 1'b0);
                        end else begin
                            send_word(word_to(tgt), pc, 1'b0);
                        end
                        pc += 4;
                        cnt++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        send_word($urandom, pc, 1'b1);
                        cnt++;
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 4))
                            0: send_word($urandom, pc, $urandom_range(0, 5) == 0);
                            1: send_word(word_to(tgt), pc, $urandom_range(0, 5) == 0);
                            2: send_word(adrp_enc(tgt, t_adrp_imm'($urandom)), pc,
                                         $urandom_range(0, 5) == 0);
                            3: send_word(addi_enc(tgt, other_reg(tgt), 12'($urandom),
                                                  1'($urandom), 1'($urandom)), pc,
                                         $urandom_range(0, 5) == 0);
                            default: send_word(addi_enc(tgt, tgt, 12'($urandom), 1'($urandom),
                                                        1'($urandom)) & ~SF_BIT, pc,
                                               $urandom_range(0, 5) == 0);
                        endcase
                        pc += 4;
                        cnt++;
                    end
                end
            end
        end

        drain();
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
